[rtl/dtm_pkg.sv]
package dtm_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_TRANS  = 2'd0,
        OP_WRITE_ACCEPT = 2'd1,
        OP_TEXT         = 2'd2,
        OP_END          = 2'd3
    } op_t;

    localparam logic [1:0] MODE_STRICT   = 2'd0;
    localparam logic [1:0] MODE_SHORTEST = 2'd1;
    localparam logic [1:0] MODE_LONGEST  = 2'd2;

    localparam logic [1:0] CFG_MATCH_MODE      = 2'd0;
    localparam logic [1:0] CFG_START_STATE     = 2'd1;
    localparam logic [1:0] CFG_PATTERN_PRESENT = 2'd2;

    localparam logic KIND_SPAN    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int SPAN_BITS = 16;

    typedef struct packed {
        logic saved;
        logic failed;
    } scan_flags_t;

    typedef struct packed {
        logic emit;
        logic kind;
        logic whole;
    } result_ctrl_t;

endpackage

[rtl/dtm_ram.sv]
module dtm_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

[rtl/dtm_step.sv]
module dtm_step #(
    parameter int STATE_BITS    = 4,
    parameter int POSITION_BITS = 16
) (
    input  dtm_pkg::op_t         op,
    input  logic                 sym_ok,
    input  logic                 entry_valid,
    input  logic [STATE_BITS-1:0] entry_to,
    input  logic                 acc_flag,
    input  logic [1:0]           mode,
    input  logic                 pattern_present,
    input  logic [STATE_BITS-1:0] start_idx,
    input  logic [STATE_BITS-1:0] cs,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [POSITION_BITS-1:0] run,
    input  logic [POSITION_BITS-1:0] saved_start,
    input  logic [POSITION_BITS-1:0] saved_len,
    input  dtm_pkg::scan_flags_t flags,
    output logic [STATE_BITS-1:0] cs_n,
    output logic [POSITION_BITS-1:0] pos_n,
    output logic [POSITION_BITS-1:0] run_n,
    output logic [POSITION_BITS-1:0] saved_start_n,
    output logic [POSITION_BITS-1:0] saved_len_n,
    output dtm_pkg::scan_flags_t flags_n,
    output dtm_pkg::result_ctrl_t res,
    output logic [POSITION_BITS-1:0] res_start,
    output logic [POSITION_BITS-1:0] res_len
);

    import dtm_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] run_inc;
    logic [POSITION_BITS-1:0] span_st;

    always_comb
    begin
        pos_inc = (pos == POS_MAX) ? pos : pos + 1'b1;
        run_inc = (run == POS_MAX) ? run : run + 1'b1;
        span_st = (pos_inc >= run_inc) ? pos_inc - run_inc : '0;

        cs_n          = cs;
        pos_n         = pos;
        run_n         = run;
        saved_start_n = saved_start;
        saved_len_n   = saved_len;
        flags_n       = flags;
        res           = '0;
        res_start     = '0;
        res_len       = '0;

        case (op)
            OP_END:
            begin
                if (mode == MODE_STRICT)
                begin
                    res.emit  = 1'b1;
                    res.kind  = KIND_VERDICT;
                    res.whole = pattern_present && !flags.failed && acc_flag;
                end
                else if (mode[1] && pattern_present && flags.saved)
                begin
                    res.emit  = 1'b1;
                    res.kind  = KIND_SPAN;
                    res_start = saved_start;
                    res_len   = saved_len;
                end
                cs_n          = start_idx;
                pos_n         = '0;
                run_n         = '0;
                saved_start_n = '0;
                saved_len_n   = '0;
                flags_n       = '0;
            end
            OP_TEXT:
            begin
                pos_n = pos_inc;
                if (pattern_present)
                begin
                    if (entry_valid && sym_ok)
                    begin
                        cs_n  = entry_to;
                        run_n = run_inc;
                        if (acc_flag)
                        begin
                            if (mode == MODE_SHORTEST)
                            begin
                                res.emit  = 1'b1;
                                res.kind  = KIND_SPAN;
                                res_start = span_st;
                                res_len   = run_inc;
                                run_n     = '0;
                                cs_n      = start_idx;
                            end
                            else if (mode[1])
                            begin
                                saved_start_n = span_st;
                                saved_len_n   = run_inc;
                                flags_n.saved = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // miss: back to start, failing character dropped
                        flags_n.failed = 1'b1;
                        cs_n           = start_idx;
                        run_n          = '0;
                        if (mode[1] && flags.saved)
                        begin
                            flags_n.saved = 1'b0;
                            res.emit      = 1'b1;
                            res.kind      = KIND_SPAN;
                            res_start     = saved_start;
                            res_len       = saved_len;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/dfa_text_matcher_top.sv]
// channel  | handshake               | payload
// ---------+-------------------------+-----------------------------------------
// input    | in_valid / in_ready     | op from_state symbol to_state
//          |                         | entry_valid accept_value
// result   | out_valid / out_ready   | result_kind span_start span_length
//          |                         | whole_match
// config   | cfg_write               | cfg_index cfg_data
//
// one beat per cycle sustained while the result channel does not stall; the staged beat
// register and then the result register lie between a beat and its result; the table read,
// launched at acceptance and addressed by the state the prior beat leaves, feeds the scan update
// after reset a clearing pass over all STATE_COUNT * ALPHABET_SIZE entries (4096 by
// default) empties the transition table; in_ready stays low meanwhile
// a held result blocks input only when the staged beat also has a result
module dfa_text_matcher_top #(
    parameter int STATE_COUNT   = 16,
    parameter int ALPHABET_SIZE = 256,
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [3:0]  from_state,
    input  logic [7:0]  symbol,
    input  logic [3:0]  to_state,
    input  logic        entry_valid,
    input  logic        accept_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [15:0] span_start,
    output logic [15:0] span_length,
    output logic        whole_match,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    import dtm_pkg::*;

    localparam int STATE_BITS = $clog2(STATE_COUNT);
    localparam int DEPTH      = STATE_COUNT * ALPHABET_SIZE;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int ENTRY_BITS = STATE_BITS + 1;
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

    function automatic logic [STATE_BITS-1:0] wrap_start(input logic [3:0] v);
        logic [STATE_BITS-1:0] r;
        r = '0;
        for (int q = 0; q < 16; q++)
        begin
            if (int'(v) >= q * STATE_COUNT && int'(v) < (q + 1) * STATE_COUNT)
            begin
                r = STATE_BITS'(int'(v) - q * STATE_COUNT);
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] tbl_addr(input logic [STATE_BITS-1:0] s,
                                                      input logic [7:0] c);
        return ADDR_BITS'(ADDR_BITS'(s) * ADDR_BITS'(ALPHABET_SIZE) + ADDR_BITS'(c));
    endfunction

    // configuration
    logic [1:0]            mode_reg, mode_next;
    logic [STATE_BITS-1:0] start_idx_reg, start_idx_next;
    logic                  pp_reg, pp_next;

    // table clearing pass
    logic                 clr_active_reg, clr_active_next;
    logic [ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;

    // scan state
    logic [STATE_BITS-1:0]    cs_reg, cs_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] run_reg, run_next;
    logic [POSITION_BITS-1:0] ss_reg, ss_next;
    logic [POSITION_BITS-1:0] sl_reg, sl_next;
    scan_flags_t              flags_reg, flags_next;
    logic                     acc_reg [STATE_COUNT];
    logic                     acc_next [STATE_COUNT];

    // staged beat
    logic stg_valid_reg, stg_valid_next;
    op_t  stg_op_reg, stg_op_next;
    logic stg_sym_ok_reg, stg_sym_ok_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [15:0] out_start_reg, out_start_next;
    logic [15:0] out_len_reg, out_len_next;
    logic        out_whole_reg, out_whole_next;

    logic                  accept;
    op_t                   in_op;
    logic                  from_ok;
    logic                  to_ok;
    logic                  sym_in_ok;
    logic                  stg_adv;
    logic                  cfg_restart;
    logic [STATE_BITS-1:0] restart_idx;
    logic [STATE_BITS-1:0] rd_state;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ENTRY_BITS-1:0] rd_entry;
    logic [STATE_BITS-1:0] acc_addr;
    logic                  acc_flag;

    logic [STATE_BITS-1:0]    cs_n;
    logic [POSITION_BITS-1:0] pos_n;
    logic [POSITION_BITS-1:0] run_n;
    logic [POSITION_BITS-1:0] ss_n;
    logic [POSITION_BITS-1:0] sl_n;
    scan_flags_t              flags_n;
    result_ctrl_t             res;
    logic [POSITION_BITS-1:0] res_start;
    logic [POSITION_BITS-1:0] res_len;

    assign in_op     = op_t'(op);
    assign from_ok   = int'(from_state) < STATE_COUNT;
    assign to_ok     = int'(to_state) < STATE_COUNT;
    assign sym_in_ok = int'(symbol) < ALPHABET_SIZE;

    assign stg_adv  = stg_valid_reg && (!res.emit || !out_valid_reg || out_ready);
    assign in_ready = !clr_active_reg && (!stg_valid_reg || stg_adv);
    assign accept   = in_valid && in_ready;

    assign cfg_restart = cfg_write &&
                         (cfg_index == CFG_START_STATE || cfg_index == CFG_PATTERN_PRESENT);
    assign restart_idx = (cfg_index == CFG_START_STATE) ? wrap_start(cfg_data)
                                                        : start_idx_reg;

    // state the next text beat starts from
    assign rd_state = cfg_restart ? restart_idx : (stg_adv ? cs_n : cs_reg);
    assign rd_addr  = tbl_addr(rd_state, sym_in_ok ? symbol : 8'd0);

    always_comb
    begin
        if (clr_active_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = accept && in_op == OP_WRITE_TRANS && from_ok && sym_in_ok && to_ok;
            wr_addr = tbl_addr(STATE_BITS'(from_state), symbol);
            wr_data = {entry_valid, STATE_BITS'(to_state)};
        end
    end

    dtm_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign acc_addr = (stg_op_reg == OP_END) ? cs_reg : rd_entry[STATE_BITS-1:0];
    assign acc_flag = acc_reg[acc_addr];

    dtm_step #(
        .STATE_BITS    (STATE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .op              (stg_op_reg),
        .sym_ok          (stg_sym_ok_reg),
        .entry_valid     (rd_entry[STATE_BITS]),
        .entry_to        (rd_entry[STATE_BITS-1:0]),
        .acc_flag        (acc_flag),
        .mode            (mode_reg),
        .pattern_present (pp_reg),
        .start_idx       (start_idx_reg),
        .cs              (cs_reg),
        .pos             (pos_reg),
        .run             (run_reg),
        .saved_start     (ss_reg),
        .saved_len       (sl_reg),
        .flags           (flags_reg),
        .cs_n            (cs_n),
        .pos_n           (pos_n),
        .run_n           (run_n),
        .saved_start_n   (ss_n),
        .saved_len_n     (sl_n),
        .flags_n         (flags_n),
        .res             (res),
        .res_start       (res_start),
        .res_len         (res_len)
    );

    always_comb
    begin
        mode_next      = mode_reg;
        start_idx_next = start_idx_reg;
        pp_next        = pp_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MATCH_MODE:      mode_next      = cfg_data[1:0];
                CFG_START_STATE:     start_idx_next = wrap_start(cfg_data);
                CFG_PATTERN_PRESENT: pp_next        = cfg_data[0];
                default:
                begin
                end
            endcase
        end

        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_next = 1'b0;
            end
        end

        cs_next    = cs_reg;
        pos_next   = pos_reg;
        run_next   = run_reg;
        ss_next    = ss_reg;
        sl_next    = sl_reg;
        flags_next = flags_reg;
        if (cfg_restart)
        begin
            cs_next    = restart_idx;
            pos_next   = '0;
            run_next   = '0;
            ss_next    = '0;
            sl_next    = '0;
            flags_next = '0;
        end
        else if (stg_adv)
        begin
            cs_next    = cs_n;
            pos_next   = pos_n;
            run_next   = run_n;
            ss_next    = ss_n;
            sl_next    = sl_n;
            flags_next = flags_n;
        end

        for (int i = 0; i < STATE_COUNT; i++)
        begin
            acc_next[i] = acc_reg[i];
        end
        if (accept && in_op == OP_WRITE_ACCEPT && from_ok)
        begin
            acc_next[STATE_BITS'(from_state)] = accept_value;
        end

        stg_valid_next  = accept ? 1'b1 : (stg_adv ? 1'b0 : stg_valid_reg);
        stg_op_next     = accept ? in_op : stg_op_reg;
        stg_sym_ok_next = accept ? sym_in_ok : stg_sym_ok_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_start_next = out_start_reg;
        out_len_next   = out_len_reg;
        out_whole_next = out_whole_reg;
        if (stg_adv && res.emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = res.kind;
            out_start_next = SPAN_BITS'(res_start);
            out_len_next   = SPAN_BITS'(res_len);
            out_whole_next = res.whole;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SHORTEST;
            start_idx_reg  <= '0;
            pp_reg         <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            cs_reg         <= '0;
            pos_reg        <= '0;
            run_reg        <= '0;
            ss_reg         <= '0;
            sl_reg         <= '0;
            flags_reg      <= '0;
            for (int i = 0; i < STATE_COUNT; i++)
            begin
                acc_reg[i] <= 1'b0;
            end
            stg_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            start_idx_reg  <= start_idx_next;
            pp_reg         <= pp_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            cs_reg         <= cs_next;
            pos_reg        <= pos_next;
            run_reg        <= run_next;
            ss_reg         <= ss_next;
            sl_reg         <= sl_next;
            flags_reg      <= flags_next;
            for (int i = 0; i < STATE_COUNT; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
            stg_valid_reg  <= stg_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_op_reg     <= stg_op_next;
        stg_sym_ok_reg <= stg_sym_ok_next;
        out_kind_reg   <= out_kind_next;
        out_start_reg  <= out_start_next;
        out_len_reg    <= out_len_next;
        out_whole_reg  <= out_whole_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign span_start  = out_start_reg;
    assign span_length = out_len_reg;
    assign whole_match = out_whole_reg;

    a_no_beat_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_active_reg |-> !in_ready
    ) else $error("input beat taken during table clearing");

    a_blocked_result_holds_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && res.emit && out_valid_reg && !out_ready) |-> !in_ready
    ) else $error("input taken while staged result cannot move");

    a_state_in_range: assert property (
        @(posedge clk) disable iff (!rst_n) int'(cs_reg) < STATE_COUNT
    ) else $error("current state out of range");

    a_run_within_position: assert property (
        @(posedge clk) disable iff (!rst_n) run_reg <= pos_reg
    ) else $error("run length exceeds text position");

endmodule

[tb/tb_dfa_text_matcher_top.sv]
`timescale 1ns / 100ps

module tb_dfa_text_matcher_top;

    import dtm_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        whole;
    } match_result_t;

    class match_scoreboard;
        logic [4:0]    trans_tbl [16][256];
        logic          accepting [16];
        logic [1:0]    mode;
        logic [3:0]    start_idx;
        logic          present;
        logic [3:0]    cur_state;
        logic [15:0]   text_pos;
        logic [15:0]   run_len;
        logic [15:0]   saved_start;
        logic [15:0]   saved_len;
        logic          saved_flag;
        logic          strict_failed;
        match_result_t expected_q [$];
        int            errors;

        function new();
            foreach (trans_tbl[i, j])
                trans_tbl[i][j] = 5'b0;
            foreach (accepting[i])
                accepting[i] = 1'b0;
            mode      = MODE_SHORTEST;
            start_idx = 4'd0;
            present   = 1'b0;
            errors    = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            cur_state     = start_idx;
            text_pos      = 16'd0;
            run_len       = 16'd0;
            saved_start   = 16'd0;
            saved_len     = 16'd0;
            saved_flag    = 1'b0;
            strict_failed = 1'b0;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_expected(logic kind, logic [15:0] st, logic [15:0] len,
                                   logic whole);
            match_result_t r;
            r.kind   = kind;
            r.start  = st;
            r.length = len;
            r.whole  = whole;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void note_config(logic [1:0] idx, logic [3:0] val);
            case (idx)
                CFG_MATCH_MODE: mode = val[1:0];
                CFG_START_STATE:
                begin
                    start_idx = val;
                    restart_scan();
                end
                CFG_PATTERN_PRESENT:
                begin
                    present = val[0];
                    restart_scan();
                end
                default: ;
            endcase
        endfunction

        function void note_beat(op_t o, logic [3:0] f, logic [7:0] s, logic [3:0] t,
                                logic ev, logic av);
            logic [4:0]  entry;
            logic [15:0] st;
            logic        ok;
            case (o)
                OP_WRITE_TRANS: trans_tbl[f][s] = ev ? {1'b1, t} : 5'b0;
                OP_WRITE_ACCEPT: accepting[f] = av;
                OP_END:
                begin
                    if (mode == MODE_STRICT)
                    begin
                        ok = present && !strict_failed && accepting[cur_state];
                        add_expected(KIND_VERDICT, 16'd0, 16'd0, ok);
                    end
                    else if (mode != MODE_SHORTEST && present && saved_flag)
                        add_expected(KIND_SPAN, saved_start, saved_len, 1'b0);
                    restart_scan();
                end
                default:
                begin
                    text_pos = bump(text_pos);
                    if (!present)
                        return;
                    entry = trans_tbl[cur_state][s];
                    if (entry[4])
                    begin
                        cur_state = entry[3:0];
                        run_len   = bump(run_len);
                        if (!accepting[cur_state])
                            return;
                        st = (text_pos >= run_len) ? text_pos - run_len : 16'd0;
                        if (mode == MODE_SHORTEST)
                        begin
                            add_expected(KIND_SPAN, st, run_len, 1'b0);
                            run_len   = 16'd0;
                            cur_state = start_idx;
                        end
                        else if (mode != MODE_STRICT)
                        begin
                            saved_start = st;
                            saved_len   = run_len;
                            saved_flag  = 1'b1;
                        end
                        return;
                    end
                    // miss: back to start, failing character is dropped
                    strict_failed = 1'b1;
                    cur_state     = start_idx;
                    run_len       = 16'd0;
                    if (mode != MODE_STRICT && mode != MODE_SHORTEST && saved_flag)
                    begin
                        saved_flag = 1'b0;
                        add_expected(KIND_SPAN, saved_start, saved_len, 1'b0);
                    end
                end
            endcase
        endfunction

        function void check_result(logic kind, logic [15:0] st, logic [15:0] len,
                                   logic whole);
            match_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual kind %0d start %0d %s",
                         $time, kind, st, $sformatf("length %0d whole %0d", len, whole));
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r.kind !== kind)
            begin
                $display("%0t: result_kind expected %0d actual %0d", $time, exp_r.kind, kind);
                errors++;
            end
            if (exp_r.start !== st)
            begin
                $display("%0t: span_start expected %0d actual %0d", $time, exp_r.start, st);
                errors++;
            end
            if (exp_r.length !== len)
            begin
                $display("%0t: span_length expected %0d actual %0d", $time, exp_r.length, len);
                errors++;
            end
            if (exp_r.whole !== whole)
            begin
                $display("%0t: whole_match expected %0d actual %0d", $time, exp_r.whole, whole);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 500000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [3:0]  from_state;
    logic [7:0]  symbol;
    logic [3:0]  to_state;
    logic        entry_valid;
    logic        accept_value;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [15:0] span_start;
    logic [15:0] span_length;
    logic        whole_match;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    match_scoreboard sb;
    logic            in_gaps;
    logic            out_gaps;
    int              hold_left;
    int              cycle_count;
    logic [3:0]      dfa_states [4];
    logic [7:0]      dfa_syms [3];

    dfa_text_matcher_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .from_state   (from_state),
        .symbol       (symbol),
        .to_state     (to_state),
        .entry_valid  (entry_valid),
        .accept_value (accept_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .span_start   (span_start),
        .span_length  (span_length),
        .whole_match  (whole_match),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_beat(op_t'(op), from_state, symbol, to_state, entry_valid, accept_value);
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_kind, span_start, span_length, whole_match);
    end

    // receiver: random stalls, or a counted hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (out_gaps)
                out_ready = ($urandom_range(99) >= 30);
            else
                out_ready = 1'b1;
        end
    end

    task automatic drive_beat(input op_t o, input logic [3:0] f, input logic [7:0] s,
                              input logic [3:0] t, input logic ev, input logic av);
        if (in_gaps)
        begin
            while ($urandom_range(99) < 30)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        op           = o;
        from_state   = f;
        symbol       = s;
        to_state     = t;
        entry_valid  = ev;
        accept_value = av;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic text_char(input logic [7:0] s);
        drive_beat(OP_TEXT, 4'($urandom), s, 4'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic end_string();
        drive_beat(OP_END, 4'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
                   1'($urandom));
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.note_config(idx, val);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    initial
    begin
        int         ph;
        int         nst;
        int         count;
        int         len;
        logic [1:0] mode_v;
        logic [3:0] start_v;
        logic       present_v;

        sb           = new();
        cycle_count  = 0;
        hold_left    = 0;
        in_gaps      = 1'b1;
        out_gaps     = 1'b1;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_WRITE_TRANS;
        from_state   = 4'd0;
        symbol       = 8'd0;
        to_state     = 4'd0;
        entry_valid  = 1'b0;
        accept_value = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_MATCH_MODE;
        cfg_data     = 4'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no pattern loaded yet: characters only advance the position
        drive_beat(OP_WRITE_TRANS, 4'd0, 8'h00, 4'd15, 1'b1, 1'b0);
        drive_beat(OP_WRITE_TRANS, 4'd15, 8'hFF, 4'd15, 1'b1, 1'b0);
        drive_beat(OP_WRITE_ACCEPT, 4'd15, 8'h00, 4'd0, 1'b0, 1'b1);
        text_char(8'h00);
        end_string();

        wait_idle();
        write_reg(CFG_PATTERN_PRESENT, 4'd1);
        text_char(8'h00);
        text_char(8'hFF);
        text_char(8'h00);
        // long receiver hold-off while spans keep coming
        hold_left = 300;
        repeat (20) text_char(8'h00);
        drive_beat(OP_WRITE_TRANS, 4'd0, 8'h00, 4'd0, 1'b0, 1'b0);
        text_char(8'h00);
        end_string();

        wait_idle();
        write_reg(CFG_MATCH_MODE, MODE_STRICT);
        end_string();
        drive_beat(OP_WRITE_TRANS, 4'd0, 8'h41, 4'd15, 1'b1, 1'b0);
        text_char(8'h41);
        text_char(8'hFF);
        end_string();
        text_char(8'h41);
        text_char(8'h42);
        end_string();

        for (ph = 0; ph < 16; ph++)
        begin
            wait_idle();
            mode_v    = 2'(ph % 4);
            start_v   = (ph == 1) ? 4'd15 : (ph == 2) ? 4'd0 : 4'($urandom_range(15));
            present_v = (ph % 6 != 5);
            in_gaps   = (ph != 7 && ph != 8);
            out_gaps  = (ph != 7 && ph != 8);
            write_reg(CFG_MATCH_MODE, {2'($urandom), mode_v});
            write_reg(CFG_START_STATE, start_v);
            write_reg(CFG_PATTERN_PRESENT, {3'($urandom), present_v});

            nst = $urandom_range(2, 4);
            dfa_states[0] = start_v;
            for (int i = 1; i < 4; i++)
                dfa_states[i] = 4'($urandom_range(15));
            for (int j = 0; j < 3; j++)
                dfa_syms[j] = 8'($urandom_range(255));
            if (ph == 3)
            begin
                dfa_syms[0] = 8'h00;
                dfa_syms[1] = 8'hFF;
            end
            for (int i = 0; i < nst; i++)
                for (int j = 0; j < 3; j++)
                    drive_beat(OP_WRITE_TRANS, dfa_states[i], dfa_syms[j],
                               dfa_states[$urandom_range(nst - 1)],
                               ($urandom_range(99) < 80), 1'($urandom));
            for (int i = 0; i < nst; i++)
                drive_beat(OP_WRITE_ACCEPT, dfa_states[i], 8'($urandom), 4'($urandom),
                           1'($urandom), ($urandom_range(99) < 40));

            count = 0;
            while (count < 20)
            begin
                if ($urandom_range(99) < 10)
                begin
                    drive_beat(op_t'($urandom_range(3)), 4'($urandom), 8'($urandom),
                               4'($urandom), 1'($urandom), 1'($urandom));
                    count++;
                end
                else
                begin
                    len = $urandom_range(10);
                    for (int k = 0; k < len; k++)
                        text_char(($urandom_range(99) < 90) ? dfa_syms[$urandom_range(2)]
                                                            : 8'($urandom_range(255)));
                    end_string();
                    count += len + 1;
                end
            end
        end

        // longest spans ended by a miss and by the end of the string
        wait_idle();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        write_reg(CFG_MATCH_MODE, MODE_LONGEST);
        write_reg(CFG_START_STATE, 4'd0);
        write_reg(CFG_PATTERN_PRESENT, 4'd1);
        drive_beat(OP_WRITE_TRANS, 4'd0, 8'h61, 4'd1, 1'b1, 1'b0);
        drive_beat(OP_WRITE_TRANS, 4'd1, 8'h61, 4'd1, 1'b1, 1'b0);
        drive_beat(OP_WRITE_TRANS, 4'd0, 8'h62, 4'd0, 1'b0, 1'b0);
        drive_beat(OP_WRITE_TRANS, 4'd1, 8'h62, 4'd0, 1'b0, 1'b0);
        drive_beat(OP_WRITE_ACCEPT, 4'd1, 8'h00, 4'd0, 1'b0, 1'b1);
        repeat (12) text_char(8'h61);
        text_char(8'h62);
        repeat (3) text_char(8'h61);
        end_string();

        wait_idle();
        repeat (8) @(negedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
